FILE: design/mss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants, wheel decoder and microcode ROM for the motor
// script sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int SCRIPT_DEPTH = 64;
  localparam int COUNT_WIDTH  = 16;
  localparam int ADDR_W       = $clog2(SCRIPT_DEPTH);
  localparam int IDX_W        = ADDR_W + 1;

  // request modes
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // script characters
  localparam logic [7:0] CH_STOP   = 8'h7E;  // ~
  localparam logic [7:0] CH_FWD    = 8'h46;  // F
  localparam logic [7:0] CH_REV    = 8'h52;  // R
  localparam logic [7:0] CH_ARC_L  = 8'h2F;  // /
  localparam logic [7:0] CH_ARC_R  = 8'h5C;  // backslash
  localparam logic [7:0] CH_SPIN_R = 8'h3E;  // >
  localparam logic [7:0] CH_SPIN_L = 8'h3C;  // <
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // drive bit positions: left fwd, left rev, right fwd, right rev
  localparam logic [3:0] DRV_LF = 4'b0001;
  localparam logic [3:0] DRV_LR = 4'b0010;
  localparam logic [3:0] DRV_RF = 4'b0100;
  localparam logic [3:0] DRV_RR = 4'b1000;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } seq_state_t;

  typedef logic [2:0] step_t;

  localparam step_t ST_FETCH_CMD = 3'd0;
  localparam step_t ST_SKIP_WS   = 3'd1;
  localparam step_t ST_TAKE_CMD  = 3'd2;
  localparam step_t ST_FETCH_ARG = 3'd3;
  localparam step_t ST_SKIP_SP   = 3'd4;
  localparam step_t ST_DIGIT     = 3'd5;
  localparam step_t ST_FETCH_DIG = 3'd6;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_WS,
    C_NUL,
    C_SPTAB,
    C_DIGIT
  } cond_t;

  typedef enum logic [2:0] {
    A_NONE,
    A_ADV,
    A_ACC,
    A_CMD,
    A_END,
    A_EXEC
  } act_t;

  typedef struct packed {
    logic  issue_rd;
    cond_t cond;
    act_t  act_t_sel;
    step_t jmp;
    act_t  act_f_sel;
    step_t nxt;
  } ucw_t;

  function automatic ucw_t mss_ucode(input step_t step);
    ucw_t w;
    w = '{issue_rd: 1'b0, cond: C_ALWAYS, act_t_sel: A_NONE, jmp: ST_FETCH_CMD,
          act_f_sel: A_NONE, nxt: ST_FETCH_CMD};
    unique case (step)
      ST_FETCH_CMD: w = '{1'b1, C_ALWAYS, A_NONE, ST_SKIP_WS,   A_NONE, ST_SKIP_WS};
      ST_SKIP_WS:   w = '{1'b0, C_WS,     A_ADV,  ST_FETCH_CMD, A_NONE, ST_TAKE_CMD};
      ST_TAKE_CMD:  w = '{1'b0, C_NUL,    A_END,  ST_FETCH_CMD, A_CMD,  ST_FETCH_ARG};
      ST_FETCH_ARG: w = '{1'b1, C_ALWAYS, A_NONE, ST_SKIP_SP,   A_NONE, ST_SKIP_SP};
      ST_SKIP_SP:   w = '{1'b0, C_SPTAB,  A_ADV,  ST_FETCH_ARG, A_NONE, ST_DIGIT};
      ST_DIGIT:     w = '{1'b0, C_DIGIT,  A_ACC,  ST_FETCH_DIG, A_EXEC, ST_FETCH_CMD};
      ST_FETCH_DIG: w = '{1'b1, C_ALWAYS, A_NONE, ST_DIGIT,     A_NONE, ST_DIGIT};
      default:      w = '{1'b0, C_ALWAYS, A_END,  ST_FETCH_CMD, A_END,  ST_FETCH_CMD};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] mss_wheels(input logic [7:0] c);
    logic [3:0] d;
    unique case (c)
      CH_FWD:    d = DRV_LF | DRV_RF;
      CH_REV:    d = DRV_LR | DRV_RR;
      CH_ARC_L:  d = DRV_LF;
      CH_ARC_R:  d = DRV_RF;
      CH_SPIN_R: d = DRV_LF | DRV_RR;
      CH_SPIN_L: d = DRV_LR | DRV_RF;
      default:   d = 4'b0000;
    endcase
    return d;
  endfunction

endpackage

FILE: design/mss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss request and result channels
// Valid/ready channels carrying the sequencer requests and drive results.
// ----------------------------------------------------------------------------
interface mss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] script_byte;

  modport source (output valid, output mode, output script_byte, input ready);
  modport sink   (input valid, input mode, input script_byte, output ready);
endinterface

interface mss_out_if;
  logic valid;
  logic ready;
  logic left_forward;
  logic left_reverse;
  logic right_forward;
  logic right_reverse;
  logic script_done;

  modport source (output valid, output left_forward, output left_reverse,
                  output right_forward, output right_reverse, output script_done,
                  input ready);
  modport sink   (input valid, input left_forward, input left_reverse,
                  input right_forward, input right_reverse, input script_done,
                  output ready);
endinterface

FILE: design/mss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/motor_script_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_script_sequencer
// Plays a text movement script on a two-wheel drive, one tick per request.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. Load, append, idle ticks and ticks
// that still have count left are answered in the accept cycle: the result
// register is loaded at that edge and a new request is taken as soon as the
// result is taken. A tick that must read the next command runs a small
// microcode program over the script RAM; each byte it looks at costs one
// RAM read and then one test, and the single registered read port of the
// script RAM sets the pace of that scan. One request is in work at a time.
// The script store has no reset; bytes beyond the loaded length read as
// zero and end the script.
// ----------------------------------------------------------------------------
module motor_script_sequencer
  import mss_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  mss_in_if.sink           in_chan,
  mss_out_if.source        out_chan
);

  // control and datapath registers
  seq_state_t               state_r, state_nxt;
  step_t                    step_r, step_nxt;
  logic [IDX_W-1:0]         wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     running_r, running_nxt;
  logic [7:0]               cmd_r, cmd_nxt;
  logic [COUNT_WIDTH-1:0]   ticks_r, ticks_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [3:0]               drive_r, drive_nxt;
  logic                     done_r, done_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     rng_r, rng_nxt;

  logic                     in_ready;
  logic                     in_acc;
  logic                     start_parse;
  logic                     finish;
  logic                     ram_we;
  logic [7:0]               ram_q;
  logic [7:0]               rd_byte;
  logic [3:0]               digit_raw;
  logic                     cond_hit;
  act_t                     act;
  ucw_t                     ucw;
  logic [COUNT_WIDTH-1:0]   cnt_eff;

  assign in_acc = in_chan.valid && in_ready;

  // script store, read every cycle at the current read position
  mss_ram #(
    .WIDTH (8),
    .DEPTH (SCRIPT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r[ADDR_W-1:0]),
    .wdata (in_chan.script_byte),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  // bytes past the loaded length or the store end read as zero
  assign rd_byte   = rng_r ? ram_q : CH_NUL;
  // an ascii digit carries its value in the low nibble
  assign digit_raw = rd_byte[3:0];

  // microcode decode
  assign ucw = mss_ucode(step_r);

  always_comb begin
    unique case (ucw.cond)
      C_ALWAYS: cond_hit = 1'b1;
      C_WS:     cond_hit = (rd_byte == CH_SPACE) || (rd_byte == CH_TAB) ||
                           (rd_byte == CH_CR) || (rd_byte == CH_LF);
      C_NUL:    cond_hit = (rd_byte == CH_NUL);
      C_SPTAB:  cond_hit = (rd_byte == CH_SPACE) || (rd_byte == CH_TAB);
      C_DIGIT:  cond_hit = (rd_byte >= CH_ZERO) && (rd_byte <= CH_NINE);
      default:  cond_hit = 1'b0;
    endcase
  end

  assign act     = cond_hit ? ucw.act_t_sel : ucw.act_f_sel;
  assign finish  = (state_r == S_RUN) && ((act == A_END) || (act == A_EXEC));
  // a missing or zero count runs once
  assign cnt_eff = (cnt_r == '0) ? COUNT_WIDTH'(1) : cnt_r;

  // a tick with no count left starts the parse program
  assign start_parse = in_acc && (mode_t'(in_chan.mode) == MODE_TICK) &&
                       running_r && (ticks_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start_parse) state_nxt = S_RUN;
      S_RUN:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs: take a request only when idle and the result slot frees up
  always_comb begin
    unique case (state_r)
      S_IDLE:  in_ready = !out_valid_r || out_chan.ready;
      S_RUN:   in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    step_nxt      = step_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    running_nxt   = running_r;
    cmd_nxt       = cmd_r;
    ticks_nxt     = ticks_r;
    cnt_nxt       = cnt_r;
    drive_nxt     = drive_r;
    done_nxt      = done_r;
    rng_nxt       = rng_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      case (mode_t'(in_chan.mode))
        MODE_LOAD: begin
          wr_idx_nxt    = '0;
          rd_idx_nxt    = '0;
          cmd_nxt       = CH_NUL;
          ticks_nxt     = '0;
          drive_nxt     = 4'b0000;
          running_nxt   = 1'b1;
          done_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
        MODE_APPEND: begin
          // bytes beyond a full store are dropped
          if (wr_idx_r < IDX_W'(SCRIPT_DEPTH)) begin
            ram_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + IDX_W'(1);
          end
          done_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
        MODE_TICK: begin
          if (!running_r) begin
            done_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
          end else if (ticks_r != '0) begin
            // current command keeps going
            drive_nxt     = mss_wheels(cmd_r);
            ticks_nxt     = ticks_r - COUNT_WIDTH'(1);
            done_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
          end else begin
            cnt_nxt  = '0;
            step_nxt = ST_FETCH_CMD;
          end
        end
        default: begin
          done_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
      endcase
    end

    if (state_r == S_RUN) begin
      // range flag travels with the registered read data
      if (ucw.issue_rd) begin
        rng_nxt = (rd_idx_r < wr_idx_r) && (rd_idx_r < IDX_W'(SCRIPT_DEPTH));
      end
      step_nxt = cond_hit ? ucw.jmp : ucw.nxt;
      case (act)
        A_ADV: rd_idx_nxt = rd_idx_r + IDX_W'(1);
        A_ACC: begin
          // count * 10 + digit, wrapping at the count width
          cnt_nxt    = (cnt_r << 3) + (cnt_r << 1) +
                       COUNT_WIDTH'(digit_raw);
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
        A_CMD: begin
          cmd_nxt    = rd_byte;
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
        A_END: begin
          // end of script: stop and go inactive
          drive_nxt     = 4'b0000;
          running_nxt   = 1'b0;
          done_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
        end
        A_EXEC: begin
          drive_nxt     = mss_wheels(cmd_r);
          ticks_nxt     = cnt_eff - COUNT_WIDTH'(1);
          done_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_FETCH_CMD;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      running_r   <= 1'b0;
      cmd_r       <= CH_NUL;
      ticks_r     <= '0;
      drive_r     <= 4'b0000;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rng_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      running_r   <= running_nxt;
      cmd_r       <= cmd_nxt;
      ticks_r     <= ticks_nxt;
      drive_r     <= drive_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      rng_r       <= rng_nxt;
    end
  end

  // count accumulator is scratch for the parse program
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
  end

  // ports
  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.left_forward  = drive_r[0];
  assign out_chan.left_reverse  = drive_r[1];
  assign out_chan.right_forward = drive_r[2];
  assign out_chan.right_reverse = drive_r[3];
  assign out_chan.script_done   = done_r;

endmodule

FILE: design/mss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks for the motor script sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mss_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic left_forward,
  input logic left_reverse,
  input logic right_forward,
  input logic right_reverse,
  input logic script_done
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no request taken while an untaken result would be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("request accepted over a pending result");

  // end of script always stops both wheels
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && script_done |->
      !left_forward && !left_reverse && !right_forward && !right_reverse)
    else $error("script end with a wheel driven");

  // a wheel is never driven both ways
  a_no_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(left_forward && left_reverse) &&
                  !(right_forward && right_reverse))
    else $error("wheel driven forward and reverse");

endmodule

bind motor_script_sequencer mss_checker u_mss_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .left_forward  (out_chan.left_forward),
  .left_reverse  (out_chan.left_reverse),
  .right_forward (out_chan.right_forward),
  .right_reverse (out_chan.right_reverse),
  .script_done   (out_chan.script_done)
);

FILE: tb/tb_motor_script_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_script_sequencer
// Self-checking bench for the script sequencer. A local model of the script
// player predicts the wheel bits and the done flag of every request; a short
// table of hand-picked requests is followed by random scripts (well-formed,
// full-buffer, appended-while-running and noise), with random gaps and
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_motor_script_sequencer;
  import mss_pkg::*;

  // slowest correct run: ~1500 requests, each with a full scan of the store plus
  // the longest sender gap and the longest sink stall, taken several times over
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned USEFUL_TARGET = 900;
  localparam int unsigned DRAIN_CYCLES = 150;  // > longest scan of the block
  localparam int unsigned TICK_GUARD = 600;

  typedef struct packed {
    logic left_forward;
    logic left_reverse;
    logic right_forward;
    logic right_reverse;
    logic script_done;
  } drive_result_t;

  // hand-written request with an optional typed-in result
  typedef struct packed {
    mode_t         mode;
    logic [7:0]    data;
    logic          fixed;
    drive_result_t want;
  } opening_row_t;

  localparam drive_result_t WHEELS_OFF = 5'b00000;
  localparam drive_result_t END_SEEN   = 5'b00001;
  localparam int OPENING_ROWS = 27;

  logic clk;
  logic rst_n;

  mss_in_if  in_bus ();
  mss_out_if out_bus ();

  motor_script_sequencer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus)
  );

  // --------------------------------------------------------------------------
  // local copy of the sequencer state
  // --------------------------------------------------------------------------
  logic [7:0]             mdl_store [SCRIPT_DEPTH];
  int unsigned            mdl_wr;
  int unsigned            mdl_rd;
  logic                   mdl_running;
  logic [7:0]             mdl_cmd;
  logic [COUNT_WIDTH-1:0] mdl_ticks;
  logic [3:0]             mdl_drive;

  drive_result_t awaited_drive [$];
  logic [7:0]    script_text [$];
  opening_row_t  opening_rows [OPENING_ROWS];
  int unsigned   mismatch_count;
  int unsigned   useful_requests;
  int unsigned   cycle_count;
  logic          quiet_sender;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_model();
    mdl_wr      = 0;
    mdl_rd      = 0;
    mdl_running = 1'b0;
    mdl_cmd     = CH_NUL;
    mdl_ticks   = '0;
    mdl_drive   = 4'b0000;
  endfunction

  // positions past the loaded length or the store end read as the end mark
  function automatic logic [7:0] script_byte_at(int unsigned pos);
    if (pos >= mdl_wr || pos >= SCRIPT_DEPTH) return CH_NUL;
    return mdl_store[pos];
  endfunction

  function automatic logic [3:0] wheels_of(logic [7:0] c);
    case (c)
      CH_FWD:    return DRV_LF | DRV_RF;
      CH_REV:    return DRV_LR | DRV_RR;
      CH_ARC_L:  return DRV_LF;
      CH_ARC_R:  return DRV_RF;
      CH_SPIN_R: return DRV_LF | DRV_RR;
      CH_SPIN_L: return DRV_LR | DRV_RF;
      default:   return 4'b0000;  // stop and unknown bytes
    endcase
  endfunction

  // advance the model by one accepted request, return the result it gives
  function automatic drive_result_t predict_drive(mode_t m, logic [7:0] b);
    logic [7:0]             c;
    logic [COUNT_WIDTH-1:0] cnt;
    logic                   done;
    drive_result_t          r;
    done = 1'b0;
    cnt  = '0;
    case (m)
      MODE_LOAD: begin
        clear_model();
        mdl_running = 1'b1;
      end
      MODE_APPEND: begin
        // bytes past a full store are dropped
        if (mdl_wr < SCRIPT_DEPTH) begin
          mdl_store[mdl_wr] = b;
          mdl_wr++;
        end
      end
      MODE_TICK: begin
        if (mdl_running) begin
          if (mdl_ticks == '0) begin
            c = script_byte_at(mdl_rd);
            while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
              mdl_rd++;
              c = script_byte_at(mdl_rd);
            end
            if (c == CH_NUL) begin
              mdl_drive   = 4'b0000;
              mdl_running = 1'b0;
              done        = 1'b1;
            end else begin
              mdl_cmd = c;
              mdl_rd++;
              c = script_byte_at(mdl_rd);
              while (c == CH_SPACE || c == CH_TAB) begin
                mdl_rd++;
                c = script_byte_at(mdl_rd);
              end
              // decimal count wraps at the count width
              while (c >= CH_ZERO && c <= CH_NINE) begin
                cnt = cnt * 10 + COUNT_WIDTH'(c - CH_ZERO);
                mdl_rd++;
                c = script_byte_at(mdl_rd);
              end
              if (cnt == '0) cnt = 1;
              mdl_ticks = cnt;
            end
          end
          if (!done) begin
            mdl_drive = wheels_of(mdl_cmd);
            mdl_ticks = mdl_ticks - 1'b1;
          end
        end
      end
      default: ;  // unused mode changes nothing
    endcase
    r.left_forward  = mdl_drive[0];
    r.left_reverse  = mdl_drive[1];
    r.right_forward = mdl_drive[2];
    r.right_reverse = mdl_drive[3];
    r.script_done   = done;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // entered on a falling edge, returns on a falling edge
  task automatic send_request(mode_t m, logic [7:0] b, logic fixed,
                              drive_result_t want);
    drive_result_t r;
    int unsigned   gap;
    logic          useful;
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= m;
    in_bus.script_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    // requests the block merely ignores do not count toward the target
    useful = (m == MODE_LOAD) || (m == MODE_APPEND && mdl_wr < SCRIPT_DEPTH) ||
             (m == MODE_TICK && mdl_running);
    r = predict_drive(m, b);
    awaited_drive.push_back(fixed ? want : r);
    if (useful) useful_requests++;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push_request(mode_t m, logic [7:0] b);
    send_request(m, b, 1'b0, WHEELS_OFF);
  endtask

  task automatic send_tick();
    push_request(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // hold the request channel idle until every result is back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (awaited_drive.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_blank(logic any_kind);
    case ($urandom_range(0, any_kind ? 3 : 1))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // unknown commands avoid blanks, digits and the end mark so counts stay small
  function automatic logic [7:0] pick_command();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: return CH_FWD;
      1: return CH_REV;
      2: return CH_ARC_L;
      3: return CH_ARC_R;
      4: return CH_SPIN_R;
      5: return CH_SPIN_L;
      6: return CH_STOP;
      default: begin
        do
          b = 8'($urandom_range(1, 255));
        while (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF ||
               (b >= CH_ZERO && b <= CH_NINE));
        return b;
      end
    endcase
  endfunction

  // append well-formed commands with optional blanks and counts to the text
  task automatic compose_script(int unsigned n_cmds, logic terminate);
    int unsigned k;
    int unsigned v;
    string       digits;
    repeat (n_cmds) begin
      repeat ($urandom_range(0, 2)) script_text.push_back(pick_blank(1'b1));
      script_text.push_back(pick_command());
      repeat ($urandom_range(0, 2)) script_text.push_back(pick_blank(1'b0));
      k = $urandom_range(0, 99);
      if (k >= 25) begin
        if (k < 70) v = $urandom_range(0, 9);
        else if (k < 85) v = $urandom_range(10, 19);
        // overflowing count that wraps back to a small one
        else v = $urandom_range(0, 9) + 65536 * $urandom_range(1, 9);
        if ($urandom_range(0, 4) == 0) script_text.push_back(CH_ZERO);
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) script_text.push_back(digits[i]);
      end
    end
    if (terminate) script_text.push_back(CH_NUL);
  endtask

  task automatic play_random_script();
    int unsigned kind;
    int unsigned pos;
    int unsigned guard;
    int unsigned r;
    kind = $urandom_range(0, 99);
    quiet_sender = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0) drain_results();
    script_text.delete();
    if (kind < 90) push_request(MODE_LOAD, 8'($urandom_range(0, 255)));
    if (kind < 60) begin
      // ordinary script, ended by the end mark or by the loaded length
      compose_script($urandom_range(1, 6), $urandom_range(0, 9) < 7);
      foreach (script_text[i]) push_request(MODE_APPEND, script_text[i]);
    end else if (kind < 75) begin
      // overfill the store so the full buffer ends the script
      while (script_text.size() < SCRIPT_DEPTH + $urandom_range(1, 6))
        compose_script(1, 1'b0);
      foreach (script_text[i]) push_request(MODE_APPEND, script_text[i]);
    end else if (kind < 90) begin
      // keep appending while the script already plays
      compose_script($urandom_range(2, 6), 1'b1);
      pos = $urandom_range(1, 3);
      for (int i = 0; i < pos && i < script_text.size(); i++)
        push_request(MODE_APPEND, script_text[i]);
      while (pos < script_text.size()) begin
        if ($urandom_range(0, 1) == 0) begin
          push_request(MODE_APPEND, script_text[pos]);
          pos++;
        end else begin
          send_tick();
        end
      end
    end else begin
      // noise: any mode with any byte
      repeat ($urandom_range(10, 30)) begin
        r = $urandom_range(0, 99);
        push_request(r < 5 ? MODE_LOAD : r < 35 ? MODE_APPEND : r < 85 ? MODE_TICK :
                     MODE_NONE, 8'($urandom_range(0, 255)));
      end
    end
    if (kind < 90) begin
      guard = 0;
      while (mdl_running && guard < TICK_GUARD) begin
        send_tick();
        guard++;
      end
      // a few ticks after the end leave the wheels as they are
      repeat ($urandom_range(0, 2)) send_tick();
    end
  endtask

  // --------------------------------------------------------------------------
  // opening table: every command, blanks, counts, end of script, idle cases
  // --------------------------------------------------------------------------
  task automatic fill_opening_rows();
    opening_rows[0]  = '{MODE_TICK,   8'h00,     1'b1, WHEELS_OFF}; // not yet loaded
    opening_rows[1]  = '{MODE_NONE,   8'hA5,     1'b1, WHEELS_OFF}; // unused mode
    opening_rows[2]  = '{MODE_LOAD,   8'hFF,     1'b1, WHEELS_OFF};
    opening_rows[3]  = '{MODE_APPEND, CH_FWD,    1'b1, WHEELS_OFF};
    opening_rows[4]  = '{MODE_APPEND, CH_SPACE,  1'b1, WHEELS_OFF};
    opening_rows[5]  = '{MODE_APPEND, 8'h32,     1'b1, WHEELS_OFF}; // count 2
    opening_rows[6]  = '{MODE_APPEND, CH_REV,    1'b1, WHEELS_OFF};
    opening_rows[7]  = '{MODE_APPEND, CH_ZERO,   1'b1, WHEELS_OFF}; // zero count
    opening_rows[8]  = '{MODE_APPEND, CH_ARC_L,  1'b1, WHEELS_OFF};
    opening_rows[9]  = '{MODE_APPEND, CH_ARC_R,  1'b1, WHEELS_OFF};
    opening_rows[10] = '{MODE_APPEND, CH_SPIN_R, 1'b1, WHEELS_OFF};
    opening_rows[11] = '{MODE_APPEND, CH_TAB,    1'b1, WHEELS_OFF};
    opening_rows[12] = '{MODE_APPEND, CH_SPIN_L, 1'b1, WHEELS_OFF};
    opening_rows[13] = '{MODE_APPEND, CH_STOP,   1'b1, WHEELS_OFF};
    opening_rows[14] = '{MODE_APPEND, 8'hFF,     1'b1, WHEELS_OFF}; // unknown command
    opening_rows[15] = '{MODE_APPEND, CH_NUL,    1'b1, WHEELS_OFF};
    opening_rows[16] = '{MODE_TICK,   8'h00,     1'b0, WHEELS_OFF};
    opening_rows[17] = '{MODE_TICK,   8'hFF,     1'b0, WHEELS_OFF};
    opening_rows[18] = '{MODE_TICK,   8'h00,     1'b0, WHEELS_OFF};
    opening_rows[19] = '{MODE_TICK,   8'h55,     1'b0, WHEELS_OFF};
    opening_rows[20] = '{MODE_TICK,   8'hAA,     1'b0, WHEELS_OFF};
    opening_rows[21] = '{MODE_TICK,   8'h00,     1'b0, WHEELS_OFF};
    opening_rows[22] = '{MODE_TICK,   8'h00,     1'b0, WHEELS_OFF};
    opening_rows[23] = '{MODE_TICK,   8'h00,     1'b0, WHEELS_OFF};
    opening_rows[24] = '{MODE_TICK,   8'h00,     1'b0, WHEELS_OFF};
    opening_rows[25] = '{MODE_TICK,   8'h00,     1'b1, END_SEEN};   // end mark
    opening_rows[26] = '{MODE_TICK,   8'h00,     1'b1, WHEELS_OFF}; // inactive
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_LOAD;
    in_bus.script_byte = 8'h00;
    rst_n              = 1'b0;
    quiet_sender       = 1'b0;
    mismatch_count     = 0;
    useful_requests    = 0;
    clear_model();
    fill_opening_rows();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < OPENING_ROWS; i++)
      send_request(opening_rows[i].mode, opening_rows[i].data, opening_rows[i].fixed,
                   opening_rows[i].want);

    // sender holds off once until every result is back
    drain_results();

    while (useful_requests < USEFUL_TARGET) play_random_script();

    in_bus.valid <= 1'b0;
    while (awaited_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random back-pressure, long open stretches now and then
  // --------------------------------------------------------------------------
  initial begin
    int unsigned open_len;
    int unsigned stall_len;
    int unsigned r;
    out_bus.ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      open_len  = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      stall_len = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      @(negedge clk);
      out_bus.ready <= 1'b1;
      repeat (open_len) @(negedge clk);
      if (stall_len > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk);
      end
    end
  end

  task automatic check_bit(string what, logic want, logic got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %b, got %b", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // compare every taken result with the oldest prediction
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_drive.size() == 0) begin
        $display("%0t ns: result with nothing expected, got lf=%b lr=%b rf=%b rr=%b done=%b",
                 $time, out_bus.left_forward, out_bus.left_reverse, out_bus.right_forward,
                 out_bus.right_reverse, out_bus.script_done);
        mismatch_count++;
      end else begin
        want = awaited_drive.pop_front();
        check_bit("left_forward", want.left_forward, out_bus.left_forward);
        check_bit("left_reverse", want.left_reverse, out_bus.left_reverse);
        check_bit("right_forward", want.right_forward, out_bus.right_forward);
        check_bit("right_reverse", want.right_reverse, out_bus.right_reverse);
        check_bit("script_done", want.script_done, out_bus.script_done);
      end
    end
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
